FILE: design/hlcs_pkg.sv
// hlcs_pkg: shared types, widths and constants of the hybrid logical clock stamper
// no dependencies; imported by every module of the block

package hlcs_pkg;

    localparam int unsigned TIME_W     = 64;
    localparam int unsigned LOGICAL_W  = 32;
    localparam int unsigned UNC_W      = 24;
    localparam int unsigned BASE_W     = 20;
    localparam int unsigned NODE_W     = 16;
    localparam int unsigned DRIFT_W    = 16;
    localparam int unsigned SRC_W      = 3;
    localparam int unsigned OP_W       = 2;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 24;

    // drift term: floor(elapsed * drift / 256e6), clamped at 2^24
    localparam int unsigned PROD_W     = TIME_W + DRIFT_W;   // 80
    localparam int unsigned PRE_SHIFT  = 14;                  // 256e6 = 2^14 * 15625
    localparam int unsigned REM_W      = 38;
    localparam int unsigned DRIFT_OUT_W = UNC_W + 1;
    localparam logic [REM_W-1:0] SAT_LIMIT = 38'd262144000000; // 15625 * 2^24
    localparam logic [35:0] DIV_RECIP  = 36'd36028797019;      // ceil(2^49 / 15625)
    localparam logic [17:0] RECIP_HI   = DIV_RECIP[35:18];
    localparam logic [17:0] RECIP_LO   = DIV_RECIP[17:0];
    localparam int unsigned RECIP_SHIFT = 49;
    localparam int unsigned PART_W     = REM_W + 18;          // 56
    localparam int unsigned QSUM_W     = PART_W + 18;         // 74
    localparam logic [DRIFT_OUT_W-1:0] DRIFT_SAT = 25'h100_0000;

    localparam logic [UNC_W-1:0]  NTP_MARGIN_US = 24'd500;
    localparam logic [UNC_W-1:0]  PTP_MARGIN_US = 24'd50;
    localparam logic [BASE_W-1:0] BASE_UNC_RESET = 20'd100;
    localparam logic [UNC_W-1:0]  MAX_UNC_RESET  = 24'd10000;
    localparam logic [UNC_W-1:0]  STORED_UNC_RESET = 24'd100;

    typedef enum logic [OP_W-1:0] {
        OP_LOCAL = 2'd0,
        OP_PEER  = 2'd1,
        OP_AFTER = 2'd2,
        OP_SYNC  = 2'd3
    } op_t;

    typedef logic [SRC_W-1:0] src_t;
    localparam src_t SRC_SYSTEM = 3'd0;
    localparam src_t SRC_NTP    = 3'd1;
    localparam src_t SRC_PTP    = 3'd2;
    localparam src_t SRC_GPS    = 3'd3;
    localparam src_t SRC_ATOMIC = 3'd4;

    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
    localparam cfg_idx_t CFG_CLOCK_SOURCE = 3'd0;
    localparam cfg_idx_t CFG_BASE_UNC     = 3'd1;
    localparam cfg_idx_t CFG_MAX_UNC      = 3'd2;
    localparam cfg_idx_t CFG_DRIFT        = 3'd3;
    localparam cfg_idx_t CFG_NODE         = 3'd4;

    // item as it travels through the drift pipeline
    typedef struct packed {
        op_t                  op;
        logic [TIME_W-1:0]    t;
        logic                 t_eq_mid;
        logic [TIME_W-1:0]    skew;
        logic [LOGICAL_W-1:0] plog;
        logic [TIME_W-1:0]    target;
    } item_t;

    // result of the state update, before the interval is formed
    typedef struct packed {
        op_t                  op;
        logic [TIME_W-1:0]    t;
        logic [TIME_W-1:0]    target;
        logic [UNC_W-1:0]     u;
        logic [LOGICAL_W-1:0] logical;
        logic [TIME_W-1:0]    peak;
    } res_t;

endpackage

FILE: design/hlcs_drift.sv
// hlcs_drift: four-stage pipeline for the drift term, elapsed * drift / 256e6
// depends on hlcs_pkg; carries the item alongside the arithmetic

module hlcs_drift (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic [hlcs_pkg::DRIFT_W-1:0]           drift_q8,
    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  logic [hlcs_pkg::TIME_W-1:0]            in_elapsed,
    input  hlcs_pkg::item_t                        in_item,
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output hlcs_pkg::item_t                        out_item,
    output logic [hlcs_pkg::DRIFT_OUT_W-1:0]       out_drift
);
    import hlcs_pkg::*;

    logic [3:0]              v_reg;
    logic [3:0]              rdy;
    item_t                   item_reg [4];
    logic [47:0]             lo_reg;
    logic [47:0]             hi_reg;
    logic                    sat2_reg;
    logic                    sat3_reg;
    logic [REM_W-1:0]        rem_reg;
    logic [PART_W-1:0]       pa_reg;
    logic [PART_W-1:0]       pb_reg;
    logic [DRIFT_OUT_W-1:0]  drift_reg;

    logic [PROD_W-1:0]       prod;
    logic [REM_W-1:0]        rem_next;
    logic                    sat_next;
    logic [QSUM_W-1:0]       qsum;
    logic [DRIFT_OUT_W-1:0]  drift_next;

    always_comb begin
        rdy[3] = !v_reg[3] || out_ready;
        rdy[2] = !v_reg[2] || rdy[3];
        rdy[1] = !v_reg[1] || rdy[2];
        rdy[0] = !v_reg[0] || rdy[1];
    end

    assign in_ready  = rdy[0];
    assign out_valid = v_reg[3];
    assign out_item  = item_reg[3];
    assign out_drift = drift_reg;

    // full product, pre-shift by the power of two, clamp test
    assign prod     = {hi_reg, 32'b0} + {32'b0, lo_reg};
    assign rem_next = prod[PRE_SHIFT+REM_W-1:PRE_SHIFT];
    assign sat_next = (|prod[PROD_W-1:PRE_SHIFT+REM_W]) || (rem_next >= SAT_LIMIT);

    // divide by 15625 through the reciprocal
    assign qsum       = {pa_reg, 18'b0} + {18'b0, pb_reg};
    assign drift_next = sat3_reg ? DRIFT_SAT
                                 : {1'b0, qsum[RECIP_SHIFT+UNC_W-1:RECIP_SHIFT]};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else begin
            if (rdy[0]) v_reg[0] <= in_valid;
            if (rdy[1]) v_reg[1] <= v_reg[0];
            if (rdy[2]) v_reg[2] <= v_reg[1];
            if (rdy[3]) v_reg[3] <= v_reg[2];
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy[0]) begin
            item_reg[0] <= in_item;
            lo_reg      <= 48'(in_elapsed[31:0]) * 48'(drift_q8);
            hi_reg      <= 48'(in_elapsed[63:32]) * 48'(drift_q8);
        end
        if (rdy[1]) begin
            item_reg[1] <= item_reg[0];
            rem_reg     <= rem_next;
            sat2_reg    <= sat_next;
        end
        if (rdy[2]) begin
            item_reg[2] <= item_reg[1];
            pa_reg      <= PART_W'(rem_reg) * PART_W'(RECIP_HI);
            pb_reg      <= PART_W'(rem_reg) * PART_W'(RECIP_LO);
            sat3_reg    <= sat2_reg;
        end
        if (rdy[3]) begin
            item_reg[3] <= item_reg[2];
            drift_reg   <= drift_next;
        end
    end

endmodule

FILE: design/hlcs_state.sv
// hlcs_state: clock state, uncertainty update and per-op logical counter stage
// depends on hlcs_pkg; fed by hlcs_drift, feeds the output stage of the top level

module hlcs_state (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic [hlcs_pkg::SRC_W-1:0]         clock_source,
    input  logic [hlcs_pkg::BASE_W-1:0]        base_unc,
    input  logic [hlcs_pkg::UNC_W-1:0]         max_unc,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  hlcs_pkg::item_t                    in_item,
    input  logic [hlcs_pkg::DRIFT_OUT_W-1:0]   in_drift,
    output logic                               out_valid,
    input  logic                               out_ready,
    output hlcs_pkg::res_t                     out_res
);
    import hlcs_pkg::*;

    logic [UNC_W-1:0]     stored_unc_reg, stored_unc_next;
    logic [TIME_W-1:0]    prev_phys_reg, prev_phys_next;
    logic [LOGICAL_W-1:0] logical_reg, logical_next;
    logic [TIME_W-1:0]    peak_reg, peak_next;
    logic                 res_v_reg;
    res_t                 res_reg, res_next;

    logic [UNC_W+1:0]     sum_u;
    logic [UNC_W-1:0]     u_cur;
    logic [UNC_W-1:0]     ntp_sum;
    logic [UNC_W-1:0]     ptp_sum;
    logic [UNC_W-1:0]     ntp_capped;
    logic [UNC_W-1:0]     ptp_capped;
    logic [LOGICAL_W-1:0] hi_logical;
    logic                 same_t;
    logic                 take;

    assign take      = in_valid && in_ready;
    assign in_ready  = !res_v_reg || out_ready;
    assign out_valid = res_v_reg;
    assign out_res   = res_reg;

    assign sum_u      = {2'b0, stored_unc_reg} + {1'b0, in_drift};
    assign u_cur      = (sum_u > {2'b0, max_unc}) ? max_unc : sum_u[UNC_W-1:0];
    assign ntp_sum    = {4'b0, base_unc} + NTP_MARGIN_US;
    assign ptp_sum    = {4'b0, base_unc} + PTP_MARGIN_US;
    assign ntp_capped = (ntp_sum > max_unc) ? max_unc : ntp_sum;
    assign ptp_capped = (ptp_sum > max_unc) ? max_unc : ptp_sum;
    assign same_t     = (in_item.t == prev_phys_reg);
    assign hi_logical = (logical_reg > in_item.plog) ? logical_reg : in_item.plog;

    always_comb begin
        stored_unc_next = stored_unc_reg;
        prev_phys_next  = prev_phys_reg;
        logical_next    = logical_reg;
        peak_next       = peak_reg;
        res_next.op     = in_item.op;
        res_next.t      = in_item.t;
        res_next.target = in_item.target;
        res_next.u      = u_cur;
        res_next.logical = '0;
        res_next.peak   = peak_reg;
        case (in_item.op)
            OP_SYNC: begin
                case (clock_source)
                    SRC_NTP, SRC_GPS: stored_unc_next = ntp_capped;
                    SRC_PTP:          stored_unc_next = ptp_capped;
                    default:          stored_unc_next = stored_unc_reg;
                endcase
                res_next.u = stored_unc_next;
            end
            OP_PEER: begin
                if (same_t) begin
                    logical_next = hi_logical + 32'd1;
                end else begin
                    prev_phys_next = in_item.t;
                    logical_next   = in_item.t_eq_mid ? in_item.plog + 32'd1 : '0;
                end
                if (in_item.skew > peak_reg) begin
                    peak_next = in_item.skew;
                end
                res_next.logical = logical_next;
                res_next.peak    = peak_next;
            end
            default: begin
                // local stamp and stamp after target
                if (same_t) begin
                    logical_next = logical_reg + 32'd1;
                end else begin
                    prev_phys_next = in_item.t;
                    logical_next   = '0;
                end
                stored_unc_next  = u_cur;
                res_next.logical = logical_next;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stored_unc_reg <= STORED_UNC_RESET;
            prev_phys_reg  <= '0;
            logical_reg    <= '0;
            peak_reg       <= '0;
            res_v_reg      <= 1'b0;
        end else begin
            if (in_ready) begin
                res_v_reg <= in_valid;
            end
            if (take) begin
                stored_unc_reg <= stored_unc_next;
                prev_phys_reg  <= prev_phys_next;
                logical_reg    <= logical_next;
                peak_reg       <= peak_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            res_reg <= res_next;
        end
    end

endmodule

FILE: design/hybrid_logical_clock_stamper_top.sv
// hybrid_logical_clock_stamper_top: top level with configuration registers,
// input stage, sync time and output stage; depends on hlcs_pkg, hlcs_drift, hlcs_state

// Hybrid logical clock stamper. Every input transfer carries an op (local stamp,
// peer stamp, stamp no earlier than a target, sync) and the current physical time
// in microseconds, and yields exactly one result transfer: an interval [t - u,
// t + u] (lifted to the target for a stamp after target, zero for a sync) with a
// logical counter, the node number, the uncertainty u and the peak peer skew seen
// so far. The block is fully pipelined and takes one item per clock when the
// result side keeps up. Items pass the input stage, then the drift pipeline (one
// stage of 32x16 partial products, one forming the product and the clamp test,
// one multiplying by the reciprocal of 15625, one forming the quotient), then the
// state update stage and the output register. All clock state (stored
// uncertainty, last physical time, logical counter, skew peak) lives in the state
// update stage, so items never see stale state; the sync time is updated as a
// sync item is taken in, ahead of the items behind it. Configuration registers
// are written through cfg_we/cfg_index/cfg_data and may only be changed while no
// item is in flight; writes to unused indexes are ignored. Valid and ready stages
// decouple the two sides, so a waiting result does not stop new input transfers
// until the pipeline is full.

module hybrid_logical_clock_stamper_top (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    // configuration write port
    input  logic                                 cfg_we,
    input  logic [hlcs_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [hlcs_pkg::CFG_DATA_W-1:0]      cfg_data,
    // input channel
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic [hlcs_pkg::OP_W-1:0]            s_op,
    input  logic [hlcs_pkg::TIME_W-1:0]          s_phys_time_us,
    input  logic [hlcs_pkg::TIME_W-1:0]          s_peer_earliest_us,
    input  logic [hlcs_pkg::TIME_W-1:0]          s_peer_latest_us,
    input  logic [hlcs_pkg::LOGICAL_W-1:0]       s_peer_logical,
    input  logic [hlcs_pkg::TIME_W-1:0]          s_target_us,
    // result channel
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic [hlcs_pkg::TIME_W-1:0]          m_stamp_earliest_us,
    output logic [hlcs_pkg::TIME_W-1:0]          m_stamp_latest_us,
    output logic [hlcs_pkg::LOGICAL_W-1:0]       m_stamp_logical,
    output logic [hlcs_pkg::NODE_W-1:0]          m_stamp_node,
    output logic [hlcs_pkg::UNC_W-1:0]           m_uncertainty_out_us,
    output logic [hlcs_pkg::TIME_W-1:0]          m_peak_skew_us
);
    import hlcs_pkg::*;

    // configuration registers
    logic [SRC_W-1:0]     clock_source_reg;
    logic [BASE_W-1:0]    base_unc_reg;
    logic [UNC_W-1:0]     max_unc_reg;
    logic [DRIFT_W-1:0]   drift_reg;
    logic [NODE_W-1:0]    node_reg;

    // sync time, kept at the input side
    logic [TIME_W-1:0]    sync_time_reg;

    // input stage
    logic                 st1_v_reg;
    op_t                  st1_op_reg;
    logic [TIME_W-1:0]    st1_phys_reg;
    logic [TIME_W-1:0]    st1_mid_reg;
    logic [TIME_W-1:0]    st1_target_reg;
    logic [LOGICAL_W-1:0] st1_plog_reg;
    logic [TIME_W-1:0]    st1_elapsed_reg;

    logic                 s_take;
    logic [TIME_W-1:0]    mid_next;
    logic [TIME_W-1:0]    elapsed_next;
    logic                 drift_in_ready;

    // peer arithmetic on the input stage
    logic [TIME_W-1:0]    diff_mp;
    logic [TIME_W-1:0]    diff_pm;
    logic                 phys_above_mid;
    item_t                st1_item;

    // drift pipeline to state stage
    logic                 dp_valid;
    logic                 dp_ready;
    item_t                dp_item;
    logic [DRIFT_OUT_W-1:0] dp_drift;

    // state stage to output stage
    logic                 rs_valid;
    logic                 rs_ready;
    res_t                 rs;

    // output stage
    logic                 m_valid_reg;
    logic [TIME_W-1:0]    early_reg, early_next;
    logic [TIME_W-1:0]    late_reg, late_next;
    logic [LOGICAL_W-1:0] logical_reg, logical_next;
    logic [NODE_W-1:0]    node_out_reg;
    logic [UNC_W-1:0]     unc_out_reg;
    logic [TIME_W-1:0]    peak_out_reg;
    logic [TIME_W-1:0]    early_raw;
    logic [TIME_W-1:0]    late_raw;

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clock_source_reg <= SRC_SYSTEM;
            base_unc_reg     <= BASE_UNC_RESET;
            max_unc_reg      <= MAX_UNC_RESET;
            drift_reg        <= '0;
            node_reg         <= '0;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_CLOCK_SOURCE: clock_source_reg <= cfg_data[SRC_W-1:0];
                CFG_BASE_UNC:     base_unc_reg     <= cfg_data[BASE_W-1:0];
                CFG_MAX_UNC:      max_unc_reg      <= cfg_data[UNC_W-1:0];
                CFG_DRIFT:        drift_reg        <= cfg_data[DRIFT_W-1:0];
                CFG_NODE:         node_reg         <= cfg_data[NODE_W-1:0];
                default:          ; // unused index, write dropped
            endcase
        end
    end

    // input transfer
    assign s_ready = !st1_v_reg || drift_in_ready;
    assign s_take  = s_valid && s_ready;

    // floor average of the peer bounds without overflow
    assign mid_next = {1'b0, s_peer_earliest_us[TIME_W-1:1]}
                    + {1'b0, s_peer_latest_us[TIME_W-1:1]}
                    + {{(TIME_W-1){1'b0}}, s_peer_earliest_us[0] & s_peer_latest_us[0]};
    // elapsed time since the most recent sync taken in, modulo 2^64
    assign elapsed_next = s_phys_time_us - sync_time_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st1_v_reg     <= 1'b0;
            sync_time_reg <= '0;
        end else begin
            if (s_ready) begin
                st1_v_reg <= s_valid;
            end
            if (s_take && (op_t'(s_op) == OP_SYNC)) begin
                sync_time_reg <= s_phys_time_us;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_take) begin
            st1_op_reg      <= op_t'(s_op);
            st1_phys_reg    <= s_phys_time_us;
            st1_mid_reg     <= mid_next;
            st1_target_reg  <= s_target_us;
            st1_plog_reg    <= s_peer_logical;
            st1_elapsed_reg <= elapsed_next;
        end
    end

    // chosen time and skew; skew reads mid - phys as a signed difference
    assign diff_mp        = st1_mid_reg - st1_phys_reg;
    assign diff_pm        = st1_phys_reg - st1_mid_reg;
    assign phys_above_mid = st1_phys_reg > st1_mid_reg;

    always_comb begin
        st1_item.op       = st1_op_reg;
        st1_item.t        = st1_phys_reg;
        st1_item.t_eq_mid = !phys_above_mid;
        st1_item.skew     = diff_mp[TIME_W-1] ? diff_pm : diff_mp;
        st1_item.plog     = st1_plog_reg;
        st1_item.target   = st1_target_reg;
        if ((st1_op_reg == OP_PEER) && !phys_above_mid) begin
            st1_item.t = st1_mid_reg;
        end
    end

    hlcs_drift u_drift (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .drift_q8   (drift_reg),
        .in_valid   (st1_v_reg),
        .in_ready   (drift_in_ready),
        .in_elapsed (st1_elapsed_reg),
        .in_item    (st1_item),
        .out_valid  (dp_valid),
        .out_ready  (dp_ready),
        .out_item   (dp_item),
        .out_drift  (dp_drift)
    );

    hlcs_state u_state (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .clock_source (clock_source_reg),
        .base_unc     (base_unc_reg),
        .max_unc      (max_unc_reg),
        .in_valid     (dp_valid),
        .in_ready     (dp_ready),
        .in_item      (dp_item),
        .in_drift     (dp_drift),
        .out_valid    (rs_valid),
        .out_ready    (rs_ready),
        .out_res      (rs)
    );

    // interval forming; the target case pushes the interval up as a whole
    assign rs_ready  = !m_valid_reg || m_ready;
    assign early_raw = rs.t - {{(TIME_W-UNC_W){1'b0}}, rs.u};
    assign late_raw  = rs.t + {{(TIME_W-UNC_W){1'b0}}, rs.u};

    always_comb begin
        early_next   = early_raw;
        late_next    = late_raw;
        logical_next = rs.logical;
        case (rs.op)
            OP_SYNC: begin
                early_next   = '0;
                late_next    = '0;
                logical_next = '0;
            end
            OP_AFTER: begin
                if (early_raw < rs.target) begin
                    early_next   = rs.target;
                    late_next    = rs.target + {{(TIME_W-UNC_W-1){1'b0}}, rs.u, 1'b0};
                    logical_next = rs.logical + 32'd1;
                end
            end
            default: ; // local and peer stamps use the raw interval
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (rs_ready) begin
            m_valid_reg <= rs_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (rs_valid && rs_ready) begin
            early_reg    <= early_next;
            late_reg     <= late_next;
            logical_reg  <= logical_next;
            node_out_reg <= node_reg;
            unc_out_reg  <= rs.u;
            peak_out_reg <= rs.peak;
        end
    end

    assign m_valid              = m_valid_reg;
    assign m_stamp_earliest_us  = early_reg;
    assign m_stamp_latest_us    = late_reg;
    assign m_stamp_logical      = logical_reg;
    assign m_stamp_node         = node_out_reg;
    assign m_uncertainty_out_us = unc_out_reg;
    assign m_peak_skew_us       = peak_out_reg;

endmodule

FILE: tb/tb_hybrid_logical_clock_stamper_top.sv
// tb_hybrid_logical_clock_stamper_top: self-checking bench for the clock stamper, with
// its own model of the stamp, drift and skew arithmetic held in a small scoreboard class
// depends on hlcs_pkg and hybrid_logical_clock_stamper_top

module tb_hybrid_logical_clock_stamper_top;
    import hlcs_pkg::*;

    localparam int unsigned CLK_HALF        = 10;
    localparam int unsigned RST_CYCLES      = 4;
    localparam int unsigned PHASES          = 8;
    localparam int unsigned ITEMS_PER_PHASE = 210;
    localparam int unsigned HOLD_PHASE      = 4;
    localparam int unsigned LONG_HOLD       = 400;
    // settling wait after the last stamp is checked, leave some margin
    localparam int unsigned SETTLE_CYCLES   = 12;
    localparam int unsigned DRAIN_LIMIT     = 5000;
    localparam int unsigned CYCLE_LIMIT     = 400000;
    localparam logic [79:0] DRIFT_DIVISOR   = 80'd256000000;

    typedef logic [TIME_W-1:0] time_us_t;

    localparam time_us_t ALL_ONES = '1;
    localparam time_us_t HALF_WAY = 64'h8000_0000_0000_0000;
    // source codes above atomic behave as the system clock
    localparam src_t     SRC_UNUSED = 3'd7;

    typedef struct {
        op_t                  op;
        time_us_t             phys;
        time_us_t             peer_earliest;
        time_us_t             peer_latest;
        logic [LOGICAL_W-1:0] peer_logical;
        time_us_t             target;
    } stamp_req_t;

    typedef struct {
        time_us_t             earliest;
        time_us_t             latest;
        logic [LOGICAL_W-1:0] logical;
        logic [NODE_W-1:0]    node;
        logic [UNC_W-1:0]     unc;
        time_us_t             peak;
    } stamp_t;

    typedef struct {
        src_t              src;
        logic [BASE_W-1:0] base;
        logic [UNC_W-1:0]  max_unc;
        logic [DRIFT_W-1:0] drift;
        logic [NODE_W-1:0] node;
    } reg_set_t;

    // clock state model plus the queue of stamps still owed by the block
    class stamp_scoreboard;
        src_t                 clock_src;
        logic [BASE_W-1:0]    base_unc;
        logic [UNC_W-1:0]     max_unc;
        logic [DRIFT_W-1:0]   drift_q8;
        logic [NODE_W-1:0]    node_id;

        logic [UNC_W-1:0]     stored_unc;
        time_us_t             sync_at;
        time_us_t             last_phys;
        logic [LOGICAL_W-1:0] logical_count;
        time_us_t             skew_peak;

        stamp_t               pending_stamps[$];
        int unsigned          failures;
        int unsigned          stamps_checked;

        function new();
            clock_src      = SRC_SYSTEM;
            base_unc       = BASE_UNC_RESET;
            max_unc        = MAX_UNC_RESET;
            drift_q8       = '0;
            node_id        = '0;
            stored_unc     = STORED_UNC_RESET;
            sync_at        = '0;
            last_phys      = '0;
            logical_count  = '0;
            skew_peak      = '0;
            failures       = 0;
            stamps_checked = 0;
        endfunction

        function void write_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] value);
            case (idx)
                CFG_CLOCK_SOURCE: clock_src = value[SRC_W-1:0];
                CFG_BASE_UNC:     base_unc  = value[BASE_W-1:0];
                CFG_MAX_UNC:      max_unc   = value[UNC_W-1:0];
                CFG_DRIFT:        drift_q8  = value[DRIFT_W-1:0];
                CFG_NODE:         node_id   = value[NODE_W-1:0];
                default: ;
            endcase
        endfunction

        // stored uncertainty plus drift since the last sync, capped
        function logic [UNC_W-1:0] drifted_unc(time_us_t phys);
            time_us_t     elapsed;
            logic [79:0]  drift_us;
            logic [80:0]  total;
            elapsed  = phys - sync_at;
            drift_us = (80'(elapsed) * 80'(drift_q8)) / DRIFT_DIVISOR;
            total    = 81'(drift_us) + 81'(stored_unc);
            if (total > 81'(max_unc))
                return max_unc;
            return total[UNC_W-1:0];
        endfunction

        function logic [UNC_W-1:0] capped_base(logic [UNC_W-1:0] margin);
            logic [UNC_W:0] total;
            total = 25'(base_unc) + 25'(margin);
            return (total > 25'(max_unc)) ? max_unc : total[UNC_W-1:0];
        endfunction

        function void note_request(stamp_req_t r);
            stamp_t           s;
            time_us_t         mid;
            time_us_t         t;
            time_us_t         diff;
            time_us_t         skew;
            logic [UNC_W-1:0] u;
            case (r.op)
                OP_SYNC: begin
                    sync_at = r.phys;
                    if (clock_src == SRC_NTP || clock_src == SRC_GPS)
                        stored_unc = capped_base(NTP_MARGIN_US);
                    else if (clock_src == SRC_PTP)
                        stored_unc = capped_base(PTP_MARGIN_US);
                    s.earliest = '0;
                    s.latest   = '0;
                    s.logical  = '0;
                    s.unc      = stored_unc;
                end
                OP_PEER: begin
                    mid  = (r.peer_earliest >> 1) + (r.peer_latest >> 1)
                         + (r.peer_earliest & r.peer_latest & 64'd1);
                    t    = (r.phys > mid) ? r.phys : mid;
                    diff = mid - r.phys;
                    skew = diff[TIME_W-1] ? (64'd0 - diff) : diff;
                    if (t == last_phys) begin
                        logical_count = ((logical_count > r.peer_logical) ?
                                         logical_count : r.peer_logical) + 32'd1;
                    end else begin
                        last_phys     = t;
                        logical_count = (t == mid) ? r.peer_logical + 32'd1 : 32'd0;
                    end
                    if (skew > skew_peak)
                        skew_peak = skew;
                    u          = drifted_unc(r.phys);
                    s.earliest = t - u;
                    s.latest   = t + u;
                    s.logical  = logical_count;
                    s.unc      = u;
                end
                default: begin
                    if (r.phys == last_phys) begin
                        logical_count = logical_count + 32'd1;
                    end else begin
                        last_phys     = r.phys;
                        logical_count = '0;
                    end
                    u          = drifted_unc(r.phys);
                    stored_unc = u;
                    s.earliest = r.phys - u;
                    s.latest   = r.phys + u;
                    s.logical  = logical_count;
                    s.unc      = u;
                    if (r.op == OP_AFTER && s.earliest < r.target) begin
                        s.latest   = s.latest + (r.target - s.earliest);
                        s.earliest = r.target;
                        s.logical  = s.logical + 32'd1;
                    end
                end
            endcase
            s.node = node_id;
            s.peak = skew_peak;
            pending_stamps.push_back(s);
        endfunction

        function void compare_field(string name, time_us_t want, time_us_t got);
            if (want !== got) begin
                failures++;
                $error("%s mismatch: expected 'h%0h, actual 'h%0h", name, want, got);
            end
        endfunction

        function void check_stamp(stamp_t got);
            stamp_t want;
            if (pending_stamps.size() == 0) begin
                failures++;
                $error("result transfer arrived with no stamp outstanding");
                return;
            end
            want = pending_stamps.pop_front();
            stamps_checked++;
            compare_field("stamp_earliest_us", want.earliest, got.earliest);
            compare_field("stamp_latest_us", want.latest, got.latest);
            compare_field("stamp_logical", 64'(want.logical), 64'(got.logical));
            compare_field("stamp_node", 64'(want.node), 64'(got.node));
            compare_field("uncertainty_out_us", 64'(want.unc), 64'(got.unc));
            compare_field("peak_skew_us", want.peak, got.peak);
        endfunction
    endclass

    // clock, reset and configuration port
    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 cfg_we    = 1'b0;
    cfg_idx_t             cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    // input channel
    logic                 s_valid            = 1'b0;
    logic                 s_ready;
    logic [OP_W-1:0]      s_op               = '0;
    time_us_t             s_phys_time_us     = '0;
    time_us_t             s_peer_earliest_us = '0;
    time_us_t             s_peer_latest_us   = '0;
    logic [LOGICAL_W-1:0] s_peer_logical     = '0;
    time_us_t             s_target_us        = '0;

    // result channel
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    time_us_t             m_stamp_earliest_us;
    time_us_t             m_stamp_latest_us;
    logic [LOGICAL_W-1:0] m_stamp_logical;
    logic [NODE_W-1:0]    m_stamp_node;
    logic [UNC_W-1:0]     m_uncertainty_out_us;
    time_us_t             m_peak_skew_us;

    stamp_scoreboard sb = new();

    // idling knobs, percent of cycles
    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;
    // long receiver hold-off: requested by the stimulus, counted by the receiver
    int unsigned hold_asked = 0;
    int unsigned hold_taken = 0;
    int unsigned hold_left  = 0;

    int unsigned ops_sent [4] = '{0, 0, 0, 0};
    int unsigned cycle_count  = 0;

    // running physical time of the well-formed traffic
    time_us_t now_us   = 64'd1_000_000;
    time_us_t last_mid = 64'd1_000_000;

    hybrid_logical_clock_stamper_top u_top (
        .aclk                 (aclk),
        .aresetn              (aresetn),
        .cfg_we               (cfg_we),
        .cfg_index            (cfg_index),
        .cfg_data             (cfg_data),
        .s_valid              (s_valid),
        .s_ready              (s_ready),
        .s_op                 (s_op),
        .s_phys_time_us       (s_phys_time_us),
        .s_peer_earliest_us   (s_peer_earliest_us),
        .s_peer_latest_us     (s_peer_latest_us),
        .s_peer_logical       (s_peer_logical),
        .s_target_us          (s_target_us),
        .m_valid              (m_valid),
        .m_ready              (m_ready),
        .m_stamp_earliest_us  (m_stamp_earliest_us),
        .m_stamp_latest_us    (m_stamp_latest_us),
        .m_stamp_logical      (m_stamp_logical),
        .m_stamp_node         (m_stamp_node),
        .m_uncertainty_out_us (m_uncertainty_out_us),
        .m_peak_skew_us       (m_peak_skew_us)
    );

    initial begin
        forever #(CLK_HALF) aclk = ~aclk;
    end

    // watchdog: a correct run ends well inside this many cycles
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("timeout after %0d cycles, %0d stamps still owed",
                 cycle_count, sb.pending_stamps.size());
        $display("== FAIL ==");
        $finish;
    end

    // receiver: random stalls, plus the long hold-off when one is requested
    always @(posedge aclk) begin
        if (hold_taken != hold_asked) begin
            hold_taken = hold_asked;
            hold_left  = LONG_HOLD;
        end
        if (hold_left != 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // result monitor: every result transfer is checked against the oldest stamp owed
    always @(posedge aclk) begin
        stamp_t got;
        if (aresetn && m_valid && m_ready) begin
            got.earliest = m_stamp_earliest_us;
            got.latest   = m_stamp_latest_us;
            got.logical  = m_stamp_logical;
            got.node     = m_stamp_node;
            got.unc      = m_uncertainty_out_us;
            got.peak     = m_peak_skew_us;
            sb.check_stamp(got);
        end
    end

    function automatic stamp_req_t stamp_request(op_t op, time_us_t phys, time_us_t pe,
                                                 time_us_t pl, logic [LOGICAL_W-1:0] plog,
                                                 time_us_t target);
        stamp_req_t r;
        r.op            = op;
        r.phys          = phys;
        r.peer_earliest = pe;
        r.peer_latest   = pl;
        r.peer_logical  = plog;
        r.target        = target;
        return r;
    endfunction

    // offer one item, holding valid and payload until the transfer happens
    task automatic send_stamp(input stamp_req_t r);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid            <= 1'b1;
        s_op               <= r.op;
        s_phys_time_us     <= r.phys;
        s_peer_earliest_us <= r.peer_earliest;
        s_peer_latest_us   <= r.peer_latest;
        s_peer_logical     <= r.peer_logical;
        s_target_us        <= r.target;
        do
            @(posedge aclk);
        while (!s_ready);
        sb.note_request(r);
        ops_sent[r.op]++;
    endtask

    // mostly plausible clock traffic around a running time, some pure noise
    task automatic make_request(output stamp_req_t r);
        int unsigned pick;
        time_us_t    mid;
        time_us_t    spread;
        if ($urandom_range(0, 99) < 12) begin
            r.op            = op_t'($urandom_range(0, 3));
            r.phys          = {$urandom, $urandom};
            r.peer_earliest = {$urandom, $urandom};
            r.peer_latest   = {$urandom, $urandom};
            r.peer_logical  = $urandom;
            r.target        = {$urandom, $urandom};
        end else begin
            // repeats keep the logical counter busy, jumps build up drift
            pick = $urandom_range(0, 99);
            if (pick >= 95)
                now_us = now_us + (64'($urandom) << $urandom_range(0, 31));
            else if (pick >= 75)
                now_us = now_us + 64'($urandom_range(1, 1 << 20));
            else if (pick >= 35)
                now_us = now_us + 64'($urandom_range(1, 3));
            pick = $urandom_range(0, 99);
            if (pick < 35)
                r.op = OP_LOCAL;
            else if (pick < 65)
                r.op = OP_PEER;
            else if (pick < 90)
                r.op = OP_AFTER;
            else
                r.op = OP_SYNC;
            r.phys = now_us;
            // peer midpoint close to our time, either side, sometimes reused
            if ($urandom_range(0, 4) == 0)
                mid = last_mid;
            else
                mid = now_us + 64'($urandom_range(0, 40)) - 64'd20;
            last_mid        = mid;
            spread          = 64'($urandom_range(0, 20000));
            r.peer_earliest = mid - spread;
            r.peer_latest   = mid + spread + 64'($urandom_range(0, 1));
            r.peer_logical  = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 50);
            // target lands on either side of the earliest bound
            r.target = now_us - 64'(sb.max_unc) - 64'd50
                     + 64'($urandom_range(0, 2 * 32'(sb.max_unc) + 100));
        end
    endtask

    task automatic wait_idle();
        while (sb.pending_stamps.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic cfg_write(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge aclk);
        sb.write_reg(idx, value);
    endtask

    task automatic apply_settings(input reg_set_t c);
        wait_idle();
        cfg_write(CFG_CLOCK_SOURCE, 24'(c.src));
        cfg_write(CFG_BASE_UNC, 24'(c.base));
        cfg_write(CFG_MAX_UNC, c.max_unc);
        cfg_write(CFG_DRIFT, 24'(c.drift));
        cfg_write(CFG_NODE, 24'(c.node));
        cfg_we <= 1'b0;
    endtask

    function automatic reg_set_t phase_settings(int unsigned p);
        reg_set_t c;
        c.src     = src_t'($urandom_range(0, 7));
        c.base    = BASE_W'($urandom_range(0, 1000000));
        c.max_unc = UNC_W'($urandom_range(0, 10000000));
        c.drift   = DRIFT_W'($urandom);
        c.node    = NODE_W'($urandom);
        case (p)
            0: begin
                c.src     = SRC_NTP;
                c.base    = 20'd100;
                c.max_unc = 24'd10000;
                c.drift   = '1;
            end
            // everything at its floor
            1: begin
                c.src     = SRC_PTP;
                c.base    = '0;
                c.max_unc = '0;
                c.drift   = '0;
                c.node    = '0;
            end
            // everything at its ceiling
            2: begin
                c.src     = SRC_GPS;
                c.base    = 20'd1000000;
                c.max_unc = 24'd10000000;
                c.drift   = '1;
                c.node    = '1;
            end
            3: begin
                c.src     = SRC_ATOMIC;
                c.base    = 20'd300;
                c.max_unc = 24'd2000;
                c.drift   = 16'd12800;
            end
            4: c.src = SRC_SYSTEM;
            5: begin
                c.src     = SRC_UNUSED;
                c.base    = 20'd1000;
                c.max_unc = 24'd600;
                c.drift   = 16'd256;
            end
            // ntp margin lands exactly on the cap
            6: begin
                c.src     = SRC_NTP;
                c.base    = 20'd9500;
                c.max_unc = 24'd10000;
                c.drift   = 16'd40000;
            end
            // ptp margin pushes past the cap
            7: begin
                c.src     = SRC_PTP;
                c.base    = 20'd990;
                c.max_unc = 24'd1000;
            end
            default: ;
        endcase
        return c;
    endfunction

    // directed items, run under the reset register values
    task automatic run_directed();
        // two local stamps at time zero: counter bumps, lower bound wraps
        send_stamp(stamp_request(OP_LOCAL, '0, '0, '0, '0, '0));
        send_stamp(stamp_request(OP_LOCAL, '0, ALL_ONES, ALL_ONES, '1, ALL_ONES));
        // top of the time range, upper bound wraps
        send_stamp(stamp_request(OP_LOCAL, ALL_ONES, '0, '0, '0, '0));
        // peer bounds both at the top: average must not overflow, t matches last time
        send_stamp(stamp_request(OP_PEER, 64'd1000, ALL_ONES, ALL_ONES, 32'd5, '0));
        // peer behind us: our time wins, counter restarts
        send_stamp(stamp_request(OP_PEER, 64'd5000, 64'd4000, 64'd4001, 32'd9, '0));
        // same time again with peer counter at the top: counter wraps to zero
        send_stamp(stamp_request(OP_PEER, 64'd5000, 64'd5000, 64'd5000, '1, '0));
        // peer ahead of us: its time wins and its counter carries over
        send_stamp(stamp_request(OP_PEER, 64'd6000, 64'd7000, 64'd7000, 32'hFFFF_FFFE, '0));
        // local stamp on that time pushes the counter past the top
        send_stamp(stamp_request(OP_LOCAL, 64'd7000, '0, '0, '0, '0));
        // skew of exactly half the range, both signs
        send_stamp(stamp_request(OP_PEER, '0, HALF_WAY, HALF_WAY, 32'd1, '0));
        send_stamp(stamp_request(OP_PEER, HALF_WAY, '0, '0, 32'd2, '0));
        // stamp after target: lifted, not lifted, lifted to the top, exactly on target
        send_stamp(stamp_request(OP_AFTER, 64'd20000, '0, '0, '0, 64'd50000));
        send_stamp(stamp_request(OP_AFTER, 64'd20000, '0, '0, '0, '0));
        send_stamp(stamp_request(OP_AFTER, 64'd30000, '0, '0, '0, ALL_ONES));
        send_stamp(stamp_request(OP_AFTER, 64'd50000, '0, '0, '0, 64'd49900));
        // sync on the system source leaves the uncertainty alone
        send_stamp(stamp_request(OP_SYNC, 64'd40000, ALL_ONES, ALL_ONES, '1, ALL_ONES));
        // widest possible peer interval
        send_stamp(stamp_request(OP_PEER, 64'd1, '0, ALL_ONES, '0, '0));
        // alternating bit patterns
        send_stamp(stamp_request(OP_LOCAL, {16{4'hA}}, {16{4'h5}}, {16{4'h5}},
                                 {8{4'h5}}, {16{4'h5}}));
        send_stamp(stamp_request(OP_PEER, {16{4'h5}}, {16{4'hA}}, {16{4'h5}},
                                 {8{4'hA}}, {16{4'hA}}));
        // sync at zero then a stamp at the far end of time
        send_stamp(stamp_request(OP_SYNC, '0, '0, '0, '0, '0));
        send_stamp(stamp_request(OP_AFTER, ALL_ONES, '0, '0, '0, ALL_ONES));
        s_valid <= 1'b0;
    endtask

    // main sequence: reset, directed items, then random phases under several settings
    initial begin
        stamp_req_t  r;
        int unsigned drain_cycles;
        repeat (RST_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        run_directed();

        for (int unsigned p = 0; p < PHASES; p++) begin
            apply_settings(phase_settings(p));
            // idling pattern rotates: none, sender gaps, receiver stalls, both light
            case (p % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 50; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 50; end
                default: begin send_idle_pct = 9; recv_stall_pct = 9; end
            endcase
            // receiver goes quiet while the sender keeps pushing, block must back up
            if (p == HOLD_PHASE)
                hold_asked++;
            for (int unsigned i = 0; i < ITEMS_PER_PHASE; i++) begin
                make_request(r);
                send_stamp(r);
            end
            s_valid <= 1'b0;
        end

        // drain whatever is still in flight
        drain_cycles = 0;
        while (sb.pending_stamps.size() != 0 && drain_cycles < DRAIN_LIMIT) begin
            @(posedge aclk);
            drain_cycles++;
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (sb.pending_stamps.size() != 0) begin
            $error("%0d stamps never came out", sb.pending_stamps.size());
            sb.failures++;
        end

        $display("covered %0d local, %0d peer, %0d after-target and %0d sync transfers",
                 ops_sent[OP_LOCAL], ops_sent[OP_PEER], ops_sent[OP_AFTER], ops_sent[OP_SYNC]);
        $display("over %0d register settings; %0d stamps checked, %0d field mismatches",
                 PHASES + 1, sb.stamps_checked, sb.failures);
        if (sb.failures == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
